@@ hdl/rhr_pkg.sv @@
// Shared types and constants for the retransmit history ring.
// No dependencies; imported by retransmit_history_ring.
`default_nettype none

package rhr_pkg;

    // Fixed field widths
    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    // Configuration register select (paddr bit 2)
    localparam logic REG_TCP_MODE     = 1'b0;
    localparam logic REG_REPEAT_LIMIT = 1'b1;

    // Reset value of the repeat limit
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 4'd8;

    // Request kinds on the input stream
    typedef enum logic
    {
        REQ_STORE  = 1'b0,
        REQ_REPEAT = 1'b1
    } req_type_t;

    // Result kinds on the output stream
    typedef enum logic [KIND_W-1:0]
    {
        KIND_STORED      = 3'd0,
        KIND_REBROADCAST = 3'd1,
        KIND_LIMIT       = 3'd2,
        KIND_OUTDATED    = 3'd3,
        KIND_IGNORED     = 3'd4
    } kind_t;

    // Controller states
    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

endpackage

`default_nettype wire

@@ hdl/retransmit_history_ring.sv @@
// Retransmit history ring: top level with controller, config registers and output stage.
// Depends on rhr_pkg and rhr_ram.
//
// Keeps the last RING_DEPTH sent packets (sequence number, handle, repeat count)
// in one RAM so that they can be sent again.
// Input stream (s_axis_*): a store request writes the packet at the write pointer
// and reports the handle it displaced; a repeat request searches the ring from
// newest to oldest and reports a rebroadcast, limit reached or outdated notice.
// With tcp_mode set, repeat requests are answered as ignored.
// Output stream (m_axis_*): exactly one result per request, in request order.
// Flow: a store or an ignored repeat goes from acceptance straight to the final
// step, which loads the output register; a repeat first searches, reading k entries
// (1..RING_DEPTH) from newest to oldest, as the RAM read port delivers one entry per
// cycle. A new request is accepted the cycle after the previous one completes,
// while its result may still sit in the output register.
// If the receiver stalls, the completed result stays in the output register and
// the next request waits in its final step until that register is taken.
// Reset clears the entry valid bits and the write pointer, sets tcp_mode to 0 and
// repeat_limit to 8; the RAM needs no clearing pass.
// APB registers: 0x0 tcp_mode (bit 0), 0x4 repeat_limit (bits 3:0).
`default_nettype none

module retransmit_history_ring #(
    parameter int unsigned RING_DEPTH  = 16,
    parameter int unsigned HANDLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rhr_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [rhr_pkg::DATA_W-1:0]    pwdata,
    output logic      [rhr_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    // Request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [47:0]                   s_axis_tdata,  // seq_num[31:0], pkt_handle[47:32]
    input  wire logic                          s_axis_tuser,  // req_type
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [55:0]                   m_axis_tdata,  // out_handle[15:0], evicted_valid[16],
                                                              // out_seq[48:17], zero[55:49]
    output logic      [rhr_pkg::KIND_W-1:0]    m_axis_tuser   // result_kind
);

    import rhr_pkg::*;

    localparam int unsigned IW = $clog2(RING_DEPTH);
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam int unsigned HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int unsigned RW = SEQ_W + HW + COUNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] SCAN_MAX = CW'(RING_DEPTH);

    // Ring index one step older, with wrap
    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
        logic [IW-1:0] r;
        r = (i == '0) ? LAST_IDX : i - 1'b1;
        return r;
    endfunction

    // Control registers
    state_t                state_reg, state_next;
    logic [IW-1:0]         wptr_reg, wptr_next;
    logic [RING_DEPTH-1:0] valid_reg, valid_next;
    logic [IW-1:0]         scan_idx_reg, scan_idx_next;
    logic [CW-1:0]         scan_cnt_reg, scan_cnt_next;
    logic                  tcp_mode_reg;
    logic [COUNT_W-1:0]    repeat_limit_reg;
    logic                  m_valid_reg, m_valid_next;

    // Payload registers
    kind_t                 kind_reg, kind_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic [HW-1:0]         hin_reg, hin_next;
    logic [IW-1:0]         hit_idx_reg, hit_idx_next;
    logic [HW-1:0]         hit_handle_reg, hit_handle_next;
    logic [COUNT_W-1:0]    hit_count_reg, hit_count_next;
    kind_t                 m_kind_reg, m_kind_next;
    logic [HANDLE_W-1:0]   m_handle_reg, m_handle_next;
    logic                  m_evict_reg, m_evict_next;
    logic [SEQ_W-1:0]      m_seq_reg, m_seq_next;

    // RAM port signals
    logic                  ram_wr_en;
    logic [IW-1:0]         ram_wr_addr;
    logic [RW-1:0]         ram_wr_data;
    logic                  ram_rd_en;
    logic [IW-1:0]         ram_rd_addr;
    logic [RW-1:0]         ram_rd_data;
    logic [SEQ_W-1:0]      rd_seq;
    logic [HW-1:0]         rd_handle;
    logic [COUNT_W-1:0]    rd_count;

    logic                  in_accept;
    logic                  out_free;
    logic                  hit;
    logic                  cfg_write;

    // Entry store: {seq, handle, count}
    rhr_ram #(
        .WIDTH (RW),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_seq    = ram_rd_data[RW-1 -: SEQ_W];
    assign rd_handle = ram_rd_data[COUNT_W +: HW];
    assign rd_count  = ram_rd_data[COUNT_W-1:0];

    // Handshake terms
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign hit           = valid_reg[scan_idx_reg] && (rd_seq == seq_reg);

    // APB: always ready, register select on bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == REG_REPEAT_LIMIT)
        begin
            prdata = DATA_W'(repeat_limit_reg);
        end
        else
        begin
            prdata = DATA_W'(tcp_mode_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcp_mode_reg     <= 1'b0;
            repeat_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_REPEAT_LIMIT)
            begin
                repeat_limit_reg <= pwdata[COUNT_W-1:0];
            end
            else
            begin
                tcp_mode_reg <= pwdata[0];
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == REQ_STORE || tcp_mode_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit || scan_cnt_reg == SCAN_MAX)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM access and result build
    always_comb
    begin
        wptr_next       = wptr_reg;
        valid_next      = valid_reg;
        scan_idx_next   = scan_idx_reg;
        scan_cnt_next   = scan_cnt_reg;
        kind_next       = kind_reg;
        seq_next        = seq_reg;
        hin_next        = hin_reg;
        hit_idx_next    = hit_idx_reg;
        hit_handle_next = hit_handle_reg;
        hit_count_next  = hit_count_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_kind_next     = m_kind_reg;
        m_handle_next   = m_handle_reg;
        m_evict_next    = m_evict_reg;
        m_seq_next      = m_seq_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = wptr_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = wptr_reg;
        ram_wr_data     = {seq_reg, hin_reg, {COUNT_W{1'b0}}};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    seq_next = s_axis_tdata[SEQ_W-1:0];
                    hin_next = s_axis_tdata[SEQ_W +: HW];
                    if (s_axis_tuser == REQ_STORE)
                    begin
                        // read the slot about to be overwritten
                        ram_rd_en = 1'b1;
                        kind_next = KIND_STORED;
                    end
                    else if (tcp_mode_reg)
                    begin
                        kind_next = KIND_IGNORED;
                    end
                    else
                    begin
                        // start the search at the newest entry
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = ring_prev(wptr_reg);
                        scan_idx_next = ring_prev(wptr_reg);
                        scan_cnt_next = CW'(1);
                        kind_next     = KIND_OUTDATED;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    hit_idx_next    = scan_idx_reg;
                    hit_handle_next = rd_handle;
                    hit_count_next  = rd_count;
                    kind_next = (rd_count < repeat_limit_reg) ? KIND_REBROADCAST : KIND_LIMIT;
                end
                else if (scan_cnt_reg != SCAN_MAX)
                begin
                    // one entry older per cycle
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = ring_prev(scan_idx_reg);
                    scan_idx_next = ring_prev(scan_idx_reg);
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = kind_reg;
                    m_seq_next    = seq_reg;
                    m_handle_next = '0;
                    m_evict_next  = 1'b0;
                    case (kind_reg)
                        KIND_STORED:
                        begin
                            if (valid_reg[wptr_reg])
                            begin
                                m_handle_next = HANDLE_W'(rd_handle);
                                m_evict_next  = 1'b1;
                            end
                            ram_wr_en            = 1'b1;
                            valid_next[wptr_reg] = 1'b1;
                            wptr_next = (wptr_reg == LAST_IDX) ? '0 : wptr_reg + 1'b1;
                        end
                        KIND_REBROADCAST:
                        begin
                            m_handle_next = HANDLE_W'(hit_handle_reg);
                            ram_wr_en     = 1'b1;
                            ram_wr_addr   = hit_idx_reg;
                            ram_wr_data   = {seq_reg, hit_handle_reg, hit_count_reg + 1'b1};
                        end
                        KIND_LIMIT:
                        begin
                            m_handle_next = HANDLE_W'(hit_handle_reg);
                        end
                        default:
                        begin
                            m_handle_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wptr_reg     <= '0;
            valid_reg    <= '0;
            scan_idx_reg <= '0;
            scan_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wptr_reg     <= wptr_next;
            valid_reg    <= valid_next;
            scan_idx_reg <= scan_idx_next;
            scan_cnt_reg <= scan_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        seq_reg        <= seq_next;
        hin_reg        <= hin_next;
        hit_idx_reg    <= hit_idx_next;
        hit_handle_reg <= hit_handle_next;
        hit_count_reg  <= hit_count_next;
        m_kind_reg     <= m_kind_next;
        m_handle_reg   <= m_handle_next;
        m_evict_reg    <= m_evict_next;
        m_seq_reg      <= m_seq_next;
    end

    // Output stream
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = {7'b0, m_seq_reg, m_evict_reg, m_handle_reg};

    // Checks
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wptr_reg <= LAST_IDX)
        else $error("write pointer out of range");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (scan_cnt_reg != '0 && scan_cnt_reg <= SCAN_MAX))
        else $error("search count out of range");

    a_write_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == ST_FINISH && out_free))
        else $error("entry written outside the final step");

    a_ptr_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_FINISH && out_free && kind_reg == KIND_STORED) |=> $stable(wptr_reg))
        else $error("write pointer moved without a store");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && (kind_reg == KIND_REBROADCAST || kind_reg == KIND_LIMIT))
        |-> valid_reg[hit_idx_reg])
        else $error("match on an empty entry");

endmodule

`default_nettype wire

@@ hdl/rhr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module rhr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ tb/rhr_checker.sv @@
// Result checker for the retransmit history ring: watches the APB port and both streams.
// Keeps its own copy of the ring and registers, predicts each result and compares in order.
// Depends on rhr_pkg.
`timescale 1ns / 1ps

module rhr_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB writes
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    // Request stream
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // seq_num[31:0], pkt_handle[47:32]
    input  wire logic        s_tuser,   // req_type
    // Result stream
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,   // out_handle[15:0], evicted_valid[16], out_seq[48:17]
    input  wire logic [2:0]  m_tuser,   // result_kind
    output int               fail_count,
    output int               pending
);

    import rhr_pkg::*;

    localparam int unsigned DEPTH = 16;

    typedef struct packed
    {
        kind_t       kind;
        logic [15:0] handle;
        logic        evicted;
        logic [31:0] seq;
    } ring_result_t;

    // Shadow ring and registers
    logic [31:0]  slot_seq    [DEPTH];
    logic [15:0]  slot_handle [DEPTH];
    logic [3:0]   slot_count  [DEPTH];
    bit           slot_used   [DEPTH];
    int unsigned  wr_slot;
    bit           tcp_on;
    logic [3:0]   limit_cfg;

    ring_result_t result_q [$];
    ring_result_t got;
    ring_result_t want;

    // Apply one request to the shadow ring and return the result it should give
    function automatic ring_result_t predict_result(input req_type_t kind_in,
                                                    input logic [31:0] seq,
                                                    input logic [15:0] handle);
        ring_result_t r;
        int unsigned  idx;
        bit           found;
        r.kind    = KIND_STORED;
        r.handle  = '0;
        r.evicted = 1'b0;
        r.seq     = seq;
        found     = 1'b0;
        if (kind_in == REQ_STORE)
        begin
            if (slot_used[wr_slot])
            begin
                r.evicted = 1'b1;
                r.handle  = slot_handle[wr_slot];
            end
            slot_seq[wr_slot]    = seq;
            slot_handle[wr_slot] = handle;
            slot_count[wr_slot]  = '0;
            slot_used[wr_slot]   = 1'b1;
            wr_slot = (wr_slot == DEPTH - 1) ? 0 : wr_slot + 1;
        end
        else if (tcp_on)
        begin
            r.kind = KIND_IGNORED;
        end
        else
        begin
            // newest entry first; first hit wins
            r.kind = KIND_OUTDATED;
            for (int step = 1; step <= DEPTH; step++)
            begin
                idx = (wr_slot + DEPTH - step) % DEPTH;
                if (!found && slot_used[idx] && slot_seq[idx] == seq)
                begin
                    found    = 1'b1;
                    r.handle = slot_handle[idx];
                    if (slot_count[idx] < limit_cfg)
                    begin
                        slot_count[idx] = slot_count[idx] + 4'd1;
                        r.kind = KIND_REBROADCAST;
                    end
                    else
                    begin
                        r.kind = KIND_LIMIT;
                    end
                end
            end
        end
        return r;
    endfunction

    // Track register writes, predict on each request, compare on each result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                slot_used[i] = 1'b0;
            wr_slot   = 0;
            tcp_on    = 1'b0;
            limit_cfg = LIMIT_RESET;
            result_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_TCP_MODE)
                    tcp_on = pwdata[0];
                else
                    limit_cfg = pwdata[3:0];
            end

            if (s_tvalid && s_tready)
                result_q.push_back(predict_result(req_type_t'(s_tuser), s_tdata[31:0],
                                                  s_tdata[47:32]));

            if (m_tvalid && m_tready)
            begin
                got.kind    = kind_t'(m_tuser);
                got.handle  = m_tdata[15:0];
                got.evicted = m_tdata[16];
                got.seq     = m_tdata[48:17];
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result: kind %0d handle %h evicted %b seq %h",
                             $time, got.kind, got.handle, got.evicted, got.seq);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch: expected kind %0d handle %h evicted %b seq %h",
                                 $time, want.kind, want.handle, want.evicted, want.seq);
                        $display("%0t:           actual   kind %0d handle %h evicted %b seq %h",
                                 $time, got.kind, got.handle, got.evicted, got.seq);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= result_q.size();
        end
    end

endmodule

@@ tb/retransmit_history_ring_test.sv @@
// Top of the retransmit history ring testbench: clock, reset, APB writes, request and
// result stream drivers, watchdog and verdict. Depends on rhr_pkg, rhr_checker and the DUT.
`timescale 1ns / 1ps

module retransmit_history_ring_test;
    import rhr_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 220;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // seq_num[31:0], pkt_handle[47:32]
    logic        s_axis_tuser = 1'b0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // out_handle[15:0], evicted_valid[16], out_seq[48:17]
    logic [2:0]  m_axis_tuser;          // result_kind

    int fail_count;
    int pending;
    int results_seen = 0;
    int idle_cycles = 0;
    bit tight_send = 1'b0;
    bit held_off = 1'b0;

    logic [31:0] recent_seq [$];
    logic [31:0] seq_ctr;

    always #1 clk = ~clk;

    retransmit_history_ring dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rhr_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tuser    (s_axis_tuser),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until the ring takes it
    task automatic send_request(input req_type_t kind_in, input logic [31:0] seq,
                                input logic [15:0] handle);
        int gap;
        gap = tight_send ? 0 : gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind_in;
        s_axis_tdata  <= {handle, seq};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (kind_in == REQ_STORE)
        begin
            recent_seq.push_back(seq);
            if (recent_seq.size() > 20)
                void'(recent_seq.pop_front());
        end
    endtask

    // Wait until the ring has answered everything, then let it settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write with a setup phase and an access phase
    task automatic reg_write(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] pick_recent(input int span);
        int n;
        n = recent_seq.size();
        if (n == 0)
            return $urandom;
        if (span > n)
            span = n;
        return recent_seq[n - 1 - $urandom_range(0, span - 1)];
    endfunction

    // Random traffic: stores of fresh, duplicate or wild sequence numbers, and repeats
    // that mostly hit recent packets so counts climb to the limit
    task automatic random_phase(input int quota, input int store_pct, input bit tcp);
        int useful;
        int r;
        logic [31:0] seq;
        useful = 0;
        while (useful < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < store_pct)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    seq = seq_ctr;
                    seq_ctr = seq_ctr + 1;
                end
                else if (r < 80)
                    seq = $urandom;
                else
                    seq = pick_recent(20);
                send_request(REQ_STORE, seq, 16'($urandom_range(0, 65535)));
                useful++;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    seq = pick_recent(4);
                else if (r < 80)
                    seq = pick_recent(20);
                else if (r < 90)
                    seq = $urandom;
                else
                    seq = seq_ctr - 32'($urandom_range(17, 60));
                send_request(REQ_REPEAT, seq, 16'($urandom));
                if (!tcp)
                    useful++;
            end
        end
    endtask

    // Receiver: random stalls, stretches always ready, and one long hold-off
    initial
    begin
        int hi;
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_off && results_seen >= 300)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                hi = ($urandom_range(0, 99) < 8) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 12);
                m_axis_tready <= 1'b1;
                repeat (hi) @(posedge clk);
                gap = gap_len();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
        if (m_axis_tvalid && m_axis_tready)
            results_seen <= results_seen + 1;

    // Watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        seq_ctr = $urandom;

        // Directed: empty ring, extreme fields, duplicates, wrap with eviction
        send_request(REQ_REPEAT, 32'h0000_0007, 16'hFFFF);
        send_request(REQ_STORE, 32'h0000_0000, 16'h0000);
        send_request(REQ_STORE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(REQ_REPEAT, 32'hFFFF_FFFF, 16'h0000);
        send_request(REQ_REPEAT, 32'h0000_0000, 16'h0000);
        send_request(REQ_STORE, 32'h0000_0005, 16'h0001);
        send_request(REQ_STORE, 32'h0000_0005, 16'h0002);
        send_request(REQ_REPEAT, 32'h0000_0005, 16'h0000);
        for (int i = 0; i < 14; i++)
            send_request(REQ_STORE, 32'd100 + i, 16'h1000 + 16'(i));
        send_request(REQ_REPEAT, 32'h0000_0000, 16'h0000);
        drain();

        // Random phases under several register settings
        reg_write(REG_TCP_MODE, 32'd0);
        reg_write(REG_REPEAT_LIMIT, 32'd15);
        random_phase(PHASE_ITEMS, 50, 1'b0);
        drain();

        reg_write(REG_REPEAT_LIMIT, 32'd0);
        tight_send = 1'b1;
        random_phase(PHASE_ITEMS, 50, 1'b0);
        drain();

        reg_write(REG_TCP_MODE, 32'd1);
        reg_write(REG_REPEAT_LIMIT, 32'd3);
        tight_send = 1'b0;
        random_phase(PHASE_ITEMS, 70, 1'b1);
        drain();

        reg_write(REG_TCP_MODE, 32'd0);
        reg_write(REG_REPEAT_LIMIT, 32'd1);
        random_phase(PHASE_ITEMS, 45, 1'b0);
        drain();

        reg_write(REG_REPEAT_LIMIT, 32'd8);
        tight_send = 1'b1;
        random_phase(PHASE_ITEMS, 50, 1'b0);
        drain();

        reg_write(REG_REPEAT_LIMIT, 32'd4);
        tight_send = 1'b0;
        random_phase(PHASE_ITEMS, 40, 1'b0);
        drain();
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ retransmit_history_ring.f @@
hdl/rhr_pkg.sv
hdl/rhr_ram.sv
hdl/retransmit_history_ring.sv
tb/rhr_checker.sv
tb/retransmit_history_ring_test.sv
